@@ rtl/e2c_pkg.sv @@
`default_nettype none
package e2c_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FACE_SIZE  = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd2;

  localparam int FS_W    = 11;
  localparam int SRC_W   = 13;
  localparam int ANG_W   = 34;
  localparam int MAG_W   = 19;
  localparam int QDIV_W  = 18;
  localparam int GUARD   = 12;
  localparam int DIV_STEPS = 18;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd536870912;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  // restoring division state for both coordinates
  typedef struct packed {
    logic [FS_W-1:0]   rem_a;
    logic [QDIV_W-1:0] q_a;
    logic              nb_a;
    logic [FS_W-1:0]   rem_b;
    logic [QDIV_W-1:0] q_b;
    logic              nb_b;
  } e2c_div_t;

  // cordic vector state; byp marks an axis vector already resolved
  typedef struct packed {
    logic                    byp;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] acc;
  } e2c_cord_t;

  // rounded arctangent of 2^-i, pi = 2^30
  function automatic logic signed [ANG_W-1:0] atan_ang(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 34'sd268435456;
      1: v = 34'sd158466703;
      2: v = 34'sd83729454;
      3: v = 34'sd42502378;
      4: v = 34'sd21333666;
      5: v = 34'sd10677233;
      6: v = 34'sd5339919;
      7: v = 34'sd2670123;
      8: v = 34'sd1335082;
      9: v = 34'sd667543;
      10: v = 34'sd333772;
      11: v = 34'sd166886;
      12: v = 34'sd83443;
      13: v = 34'sd41722;
      14: v = 34'sd20861;
      15: v = 34'sd10430;
      16: v = 34'sd5215;
      17: v = 34'sd2608;
      18: v = 34'sd1304;
      19: v = 34'sd652;
      20: v = 34'sd326;
      21: v = 34'sd163;
      22: v = 34'sd81;
      23: v = 34'sd41;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/e2c_div_cell.sv @@
`default_nettype none
module e2c_div_cell #(
  parameter int SIDE_W = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [e2c_pkg::FS_W-1:0]  fs,
  input  wire logic                      in_valid,
  input  wire e2c_pkg::e2c_div_t         in_d,
  input  wire logic [SIDE_W-1:0]         in_side,
  output logic                           out_valid,
  output e2c_pkg::e2c_div_t              out_d,
  output logic [SIDE_W-1:0]              out_side
);
  import e2c_pkg::*;

  logic              valid_r;
  e2c_div_t          d_r, d_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [FS_W:0]     ta, tb;

  // one quotient bit per coordinate
  always_comb begin
    ta = {in_d.rem_a, in_d.nb_a};
    tb = {in_d.rem_b, in_d.nb_b};
    d_nxt = in_d;
    d_nxt.nb_a = 1'b0;
    d_nxt.nb_b = 1'b0;
    if (ta >= {1'b0, fs}) begin
      d_nxt.rem_a = FS_W'(ta - {1'b0, fs});
      d_nxt.q_a   = {in_d.q_a[QDIV_W-2:0], 1'b1};
    end else begin
      d_nxt.rem_a = ta[FS_W-1:0];
      d_nxt.q_a   = {in_d.q_a[QDIV_W-2:0], 1'b0};
    end
    if (tb >= {1'b0, fs}) begin
      d_nxt.rem_b = FS_W'(tb - {1'b0, fs});
      d_nxt.q_b   = {in_d.q_b[QDIV_W-2:0], 1'b1};
    end else begin
      d_nxt.rem_b = tb[FS_W-1:0];
      d_nxt.q_b   = {in_d.q_b[QDIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

@@ rtl/e2c_cordic_cell.sv @@
`default_nettype none
module e2c_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire e2c_pkg::e2c_cord_t in_c,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output e2c_pkg::e2c_cord_t     out_c,
  output logic [SIDE_W-1:0]      out_side
);
  import e2c_pkg::*;

  logic                    valid_r;
  e2c_cord_t               c_r, c_nxt;
  logic [SIDE_W-1:0]       side_r;
  logic signed [ANG_W-1:0] dx, dy;

  // one vectoring micro-rotation
  always_comb begin
    dx = in_c.y >>> STEP;
    dy = in_c.x >>> STEP;
    c_nxt = in_c;
    if (!in_c.byp) begin
      if (in_c.y > 0) begin
        c_nxt.x   = in_c.x + dx;
        c_nxt.y   = in_c.y - dy;
        c_nxt.acc = in_c.acc + atan_ang(STEP);
      end else begin
        c_nxt.x   = in_c.x - dx;
        c_nxt.y   = in_c.y + dy;
        c_nxt.acc = in_c.acc - atan_ang(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_c     = c_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

@@ rtl/e2c_polar.sv @@
`default_nettype none
module e2c_polar #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [e2c_pkg::ANG_W-1:0]  in_x,
  input  wire logic signed [e2c_pkg::ANG_W-1:0]  in_y,
  input  wire logic [SIDE_W-1:0]                 in_side,
  output logic                                   out_valid,
  output logic signed [e2c_pkg::ANG_W-1:0]       out_ang,
  output logic [e2c_pkg::MAG_W-1:0]              out_mag,
  output logic [SIDE_W-1:0]                      out_side
);
  import e2c_pkg::*;

  logic              pre_valid_r;
  e2c_cord_t         pre_r, pre_nxt;
  logic [SIDE_W-1:0] pre_side_r;

  logic              v_w [STEPS+1];
  e2c_cord_t         c_w [STEPS+1];
  logic [SIDE_W-1:0] s_w [STEPS+1];

  logic                    m1_valid_r, m2_valid_r;
  logic                    m1_byp_r;
  logic [63:0]             m1_prod_r;
  logic [MAG_W-1:0]        m1_raw_r;
  logic signed [ANG_W-1:0] m1_ang_r, m2_ang_r;
  logic [SIDE_W-1:0]       m1_side_r, m2_side_r;
  logic [MAG_W-1:0]        m2_mag_r, m2_mag_nxt;
  logic [63:0]             rnd;

  // axis cases, half-plane fold and guard bits
  always_comb begin
    pre_nxt.byp = 1'b0;
    pre_nxt.x   = in_x;
    pre_nxt.y   = in_y;
    pre_nxt.acc = '0;
    if (in_y == 0) begin
      pre_nxt.byp = 1'b1;
      pre_nxt.acc = (in_x < 0) ? ANG_PI : '0;
      pre_nxt.x   = (in_x < 0) ? -in_x : in_x;
    end else if (in_x == 0) begin
      pre_nxt.byp = 1'b1;
      pre_nxt.acc = (in_y > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
      pre_nxt.x   = (in_y > 0) ? in_y : -in_y;
    end else if (in_x < 0) begin
      pre_nxt.acc = (in_y > 0) ? ANG_PI : -ANG_PI;
      pre_nxt.x   = (-in_x) <<< GUARD;
      pre_nxt.y   = (-in_y) <<< GUARD;
    end else begin
      pre_nxt.x   = in_x <<< GUARD;
      pre_nxt.y   = in_y <<< GUARD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (en) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r      <= pre_nxt;
      pre_side_r <= in_side;
    end
  end

  assign v_w[0] = pre_valid_r;
  assign c_w[0] = pre_r;
  assign s_w[0] = pre_side_r;

  // rotation cells
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    e2c_cordic_cell #(.STEP(k), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_w[k]),
      .in_c     (c_w[k]),
      .in_side  (s_w[k]),
      .out_valid(v_w[k+1]),
      .out_c    (c_w[k+1]),
      .out_side (s_w[k+1])
    );
  end

  // gain correction for rotated vectors: multiply, then round and drop guard bits; axis vectors pass through
  assign rnd = m1_prod_r + (64'd1 << (29 + GUARD));
  always_comb begin
    if (m1_byp_r) begin
      m2_mag_nxt = m1_raw_r;
    end else begin
      m2_mag_nxt = MAG_W'(rnd >> (30 + GUARD));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= v_w[STEPS];
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_byp_r  <= c_w[STEPS].byp;
      m1_prod_r <= 64'(c_w[STEPS].x[30:0]) * 64'(INV_GAIN_Q30);
      m1_raw_r  <= c_w[STEPS].x[MAG_W-1:0];
      m1_ang_r  <= c_w[STEPS].acc;
      m1_side_r <= s_w[STEPS];
      m2_mag_r  <= m2_mag_nxt;
      m2_ang_r  <= m1_ang_r;
      m2_side_r <= m1_side_r;
    end
  end

  assign out_valid = m2_valid_r;
  assign out_ang   = m2_ang_r;
  assign out_mag   = m2_mag_r;
  assign out_side  = m2_side_r;
endmodule
`default_nettype wire

@@ rtl/equirect_to_cubemap_sampler.sv @@
// pipeline from accepted word to result: input stage, divider cells, direction stage, the two
// polar units with their cordic cell chains, scale stage and output register
// throughput: one word per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low rst_n clears all valid flags and loads the
// registers with face_size 256, src_width 1024, src_height 512
`default_nettype none
module equirect_to_cubemap_sampler #(
  parameter int MAX_FACE_SIZE = 1024,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_addr,
  input  wire logic [e2c_pkg::SRC_W-1:0]   cfg_wdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // face[2:0], col[12:3], row[22:13], zero pad [23]
  input  wire logic [23:0]                 in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // u_low[11:0], v_low[23:12], u_high[35:24], v_high[47:36], s_weight[64:48],
  // t_weight[81:65], dest_x[93:82], dest_y[105:94], zero pad [111:106]
  output logic [111:0]                     out_tdata
);
  import e2c_pkg::*;

  localparam int DIV_SIDE = 3 + 2 + 24;
  localparam int P1_SIDE  = 18 + 24;
  localparam int P2_SIDE  = ANG_W + 24;

  logic [FS_W-1:0]  face_size_r;
  logic [SRC_W-1:0] src_width_r, src_height_r;
  logic [FS_W-1:0]  fs;
  logic [SRC_W-1:0] w_eff, h_eff;
  logic [11:0]      wm1, hm1;
  logic             en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r  <= 11'd256;
      src_width_r  <= 13'd1024;
      src_height_r <= 13'd512;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FACE_SIZE:  face_size_r  <= cfg_wdata[FS_W-1:0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    if (face_size_r == '0) fs = FS_W'(1);
    else if (32'(face_size_r) > MAX_FACE_SIZE) fs = FS_W'(MAX_FACE_SIZE);
    else fs = face_size_r;
    if (src_width_r == '0) w_eff = 13'd1;
    else if (src_width_r > 13'd4096) w_eff = 13'd4096;
    else w_eff = src_width_r;
    if (src_height_r == '0) h_eff = 13'd1;
    else if (src_height_r > 13'd4096) h_eff = 13'd4096;
    else h_eff = src_height_r;
    wm1 = 12'(w_eff - 13'd1);
    hm1 = 12'(h_eff - 13'd1);
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input stage: face offsets and divider seed
  logic [2:0]  in_face;
  logic [9:0]  in_col, in_row;
  logic [11:0] ox, oy;
  logic        s0_valid_r;
  e2c_div_t    s0_d_r, s0_d_nxt;
  logic [DIV_SIDE-1:0] s0_side_r, s0_side_nxt;

  assign in_face = in_tdata[2:0];
  assign in_col  = in_tdata[12:3];
  assign in_row  = in_tdata[22:13];

  always_comb begin
    ox = '0;
    oy = '0;
    case (in_face)
      3'd0: begin ox = 12'(fs); oy = 12'(3 * 12'(fs)); end
      3'd1: begin ox = '0; oy = 12'(fs); end
      3'd2: begin ox = 12'(fs); oy = 12'(fs); end
      3'd3: begin ox = 12'(2 * 12'(fs)); oy = 12'(fs); end
      3'd4: begin ox = 12'(fs); oy = '0; end
      3'd5: begin ox = 12'(fs); oy = 12'(2 * 12'(fs)); end
      default: begin ox = '0; oy = '0; end
    endcase
    s0_d_nxt.rem_a = FS_W'(in_col[9:1]);
    s0_d_nxt.nb_a  = in_col[0];
    s0_d_nxt.q_a   = '0;
    s0_d_nxt.rem_b = FS_W'(in_row[9:1]);
    s0_d_nxt.nb_b  = in_row[0];
    s0_d_nxt.q_b   = '0;
    s0_side_nxt = {12'(12'(in_row) + oy), 12'(12'(in_col) + ox),
                   (11'(in_row) > fs), (11'(in_col) > fs), in_face};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r    <= s0_d_nxt;
      s0_side_r <= s0_side_nxt;
    end
  end

  // divider cells
  logic                dv_v [DIV_STEPS+1];
  e2c_div_t            dv_d [DIV_STEPS+1];
  logic [DIV_SIDE-1:0] dv_s [DIV_STEPS+1];

  assign dv_v[0] = s0_valid_r;
  assign dv_d[0] = s0_d_r;
  assign dv_s[0] = s0_side_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    e2c_div_cell #(.SIDE_W(DIV_SIDE)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .fs       (fs),
      .in_valid (dv_v[k]),
      .in_d     (dv_d[k]),
      .in_side  (dv_s[k]),
      .out_valid(dv_v[k+1]),
      .out_d    (dv_d[k+1]),
      .out_side (dv_s[k+1])
    );
  end

  // direction vector from face rules
  logic [17:0]        qa, qb;
  logic signed [17:0] am, bm, px, py, pz;
  logic [2:0]         dv_face;
  logic               dir_valid_r;
  logic signed [17:0] dir_x_r, dir_y_r;
  logic [P1_SIDE-1:0] dir_side_r;

  assign dv_face = dv_s[DIV_STEPS][2:0];
  assign qa = dv_s[DIV_STEPS][3] ? 18'd131072 : dv_d[DIV_STEPS].q_a;
  assign qb = dv_s[DIV_STEPS][4] ? 18'd131072 : dv_d[DIV_STEPS].q_b;
  // quotient reaches 2.0, so it is widened before going signed
  assign am = 18'($signed({1'b0, qa}) - 19'(ONE_Q16));
  assign bm = 18'($signed({1'b0, qb}) - 19'(ONE_Q16));

  always_comb begin
    px = '0;
    py = '0;
    pz = '0;
    case (dv_face)
      3'd0: begin px = -ONE_Q16; py = am; pz = bm; end
      3'd1: begin px = am; py = -ONE_Q16; pz = -bm; end
      3'd2: begin px = ONE_Q16; py = am; pz = -bm; end
      3'd3: begin px = -am; py = ONE_Q16; pz = -bm; end
      3'd4: begin px = bm; py = am; pz = ONE_Q16; end
      3'd5: begin px = -bm; py = am; pz = -ONE_Q16; end
      default: begin px = '0; py = '0; pz = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_valid_r <= 1'b0;
    end else if (en) begin
      dir_valid_r <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x_r    <= px;
      dir_y_r    <= py;
      dir_side_r <= {dv_s[DIV_STEPS][DIV_SIDE-1:5], pz};
    end
  end

  // azimuth and horizontal radius
  logic                    p1_valid;
  logic signed [ANG_W-1:0] p1_ang;
  logic [MAG_W-1:0]        p1_mag;
  logic [P1_SIDE-1:0]      p1_side;

  e2c_polar #(.STEPS(CORDIC_STEPS), .SIDE_W(P1_SIDE)) u_azim (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dir_valid_r),
    .in_x     (ANG_W'(dir_x_r)),
    .in_y     (ANG_W'(dir_y_r)),
    .in_side  (dir_side_r),
    .out_valid(p1_valid),
    .out_ang  (p1_ang),
    .out_mag  (p1_mag),
    .out_side (p1_side)
  );

  // elevation
  logic                    p2_valid;
  logic signed [ANG_W-1:0] p2_ang;
  logic [MAG_W-1:0]        p2_mag;
  logic [P2_SIDE-1:0]      p2_side;
  logic signed [17:0]      p1_z;

  assign p1_z = p1_side[17:0];

  e2c_polar #(.STEPS(CORDIC_STEPS), .SIDE_W(P2_SIDE)) u_elev (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p1_valid),
    .in_x     (ANG_W'(p1_mag)),
    .in_y     (ANG_W'(p1_z)),
    .in_side  ({p1_side[P1_SIDE-1:18], p1_ang}),
    .out_valid(p2_valid),
    .out_ang  (p2_ang),
    .out_mag  (p2_mag),
    .out_side (p2_side)
  );

  // saturate angles and scale by face size
  logic signed [ANG_W-1:0] theta, phi, theta_raw;
  logic [31:0]             tu, tv;
  logic                    sc_valid_r;
  logic [42:0]             uprod_r, vprod_r;
  logic [23:0]             sc_dest_r;

  assign theta_raw = p2_side[ANG_W-1:0];

  always_comb begin
    theta = theta_raw;
    if (theta_raw > ANG_PI) theta = ANG_PI;
    if (theta_raw < -ANG_PI) theta = -ANG_PI;
    phi = p2_ang;
    if (p2_ang > ANG_HALF_PI) phi = ANG_HALF_PI;
    if (p2_ang < -ANG_HALF_PI) phi = -ANG_HALF_PI;
    tu = 32'(theta + ANG_PI);
    tv = 32'(ANG_HALF_PI - phi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (en) begin
      sc_valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uprod_r   <= 43'(fs) * 43'(tu);
      vprod_r   <= 43'(fs) * 43'(tv);
      sc_dest_r <= p2_side[P2_SIDE-1:ANG_W];
    end
  end

  // corners, weights and output word
  logic [29:0]  uf, vf;
  logic [13:0]  ui, vi;
  logic [11:0]  u1, v1, u2, v2;
  logic [29:0]  sd, td;
  logic [16:0]  sw, tw;
  logic [111:0] out_tdata_r, out_tdata_nxt;

  always_comb begin
    uf = uprod_r[42:13];
    vf = vprod_r[42:13];
    ui = uf[29:16];
    vi = vf[29:16];
    u1 = (ui > 14'(wm1)) ? wm1 : ui[11:0];
    v1 = (vi > 14'(hm1)) ? hm1 : vi[11:0];
    u2 = (u1 >= wm1) ? wm1 : 12'(u1 + 12'd1);
    v2 = (v1 >= hm1) ? hm1 : 12'(v1 + 12'd1);
    sd = uf - {2'b00, u1, 16'd0};
    td = vf - {2'b00, v1, 16'd0};
    sw = (sd > 30'd65536) ? 17'd65536 : sd[16:0];
    tw = (td > 30'd65536) ? 17'd65536 : td[16:0];
    out_tdata_nxt = {6'd0, sc_dest_r[23:12], sc_dest_r[11:0], tw, sw, v2, u2, v1, u1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
endmodule
`default_nettype wire
